FILE: sv/assert_macros.svh
// Assertion macros used by the checker file cbt_checker.sv.
// Needs nothing else; each macro takes a clock and a synchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check that a stalled valid stays up on the next edge.
`define ASSERT_HOLD(label, clk, rst, vld, rdy) \
  label: assert property (@(posedge clk) disable iff (rst) (vld && !rdy) |=> vld) \
    else $error("valid dropped while stalled");

`endif

FILE: sv/cbt_pkg.sv
// Types and constants for the chunked blob transfer checker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cbt_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned CodeW = 4;
  localparam int unsigned InDataW  = 240;
  localparam int unsigned OutDataW = 8;

  localparam logic [OpW-1:0] OP_ANNOUNCE = 2'd0;
  localparam logic [OpW-1:0] OP_CHUNK    = 2'd1;
  localparam logic [OpW-1:0] OP_COMPLETE = 2'd2;

  localparam logic [CodeW-1:0] ERR_OK         = 4'd0;
  localparam logic [CodeW-1:0] ERR_NO_SESSION = 4'd1;
  localparam logic [CodeW-1:0] ERR_IDENTITY   = 4'd2;
  localparam logic [CodeW-1:0] ERR_EMPTY      = 4'd3;
  localparam logic [CodeW-1:0] ERR_GAP        = 4'd4;
  localparam logic [CodeW-1:0] ERR_BEYOND     = 4'd5;
  localparam logic [CodeW-1:0] ERR_OVERRUN    = 4'd6;
  localparam logic [CodeW-1:0] ERR_CHECKSUM   = 4'd7;
  localparam logic [CodeW-1:0] ERR_INCOMPLETE = 4'd8;

  // Member order puts stream_key in the lowest bits and opcode on top.
  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic [15:0]    chunk_length;
    logic [31:0]    chunk_offset;
    logic [63:0]    check_value;
    logic [31:0]    total_length;
    logic [31:0]    blob_kind;
    logic [31:0]    meta_rev;
    logic [31:0]    stream_key;
  } msg_t;

  // accepted sits in bit 0.
  typedef struct packed {
    logic             session_open;
    logic [CodeW-1:0] error_code;
    logic             accepted;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/cbt_in_stage.sv
// Input register stage of the checker: holds one message beat.
// Depends on cbt_pkg for the message type.
`default_nettype none

module cbt_in_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [cbt_pkg::InDataW-1:0]   s_tdata,
  input  wire logic [cbt_pkg::OpW-1:0]       s_tuser,
  output      cbt_pkg::msg_t                 msg,
  output      logic                          msg_valid,
  input  wire logic                          msg_ready
);

  assign s_tready = !msg_valid || msg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (s_tready) begin
      msg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      msg <= cbt_pkg::msg_t'({s_tuser, s_tdata});
    end
  end

endmodule

`default_nettype wire

FILE: sv/cbt_engine.sv
// Session state and message checks of the checker.
// Depends on cbt_pkg for message, result and code constants.
`default_nettype none

module cbt_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cbt_pkg::msg_t    msg,
  input  wire logic             take,
  output      cbt_pkg::result_t res
);

  logic        session_active, session_active_next;
  logic [31:0] held_stream, held_stream_next;
  logic [31:0] held_version, held_version_next;
  logic [31:0] held_kind, held_kind_next;
  logic [31:0] held_total, held_total_next;
  logic [63:0] held_check, held_check_next;
  logic [31:0] expected_offset, expected_offset_next;

  logic                      id_match;
  logic                      close;
  logic [31:0]               room;
  logic [31:0]               len_ext;
  logic [cbt_pkg::CodeW-1:0] code;

  assign id_match = (msg.stream_key == held_stream) && (msg.meta_rev == held_version);
  assign room     = held_total - msg.chunk_offset;
  assign len_ext  = {16'd0, msg.chunk_length};

  always_comb begin
    code                 = cbt_pkg::ERR_OK;
    close                = 1'b0;
    session_active_next  = session_active;
    held_stream_next     = held_stream;
    held_version_next    = held_version;
    held_kind_next       = held_kind;
    held_total_next      = held_total;
    held_check_next      = held_check;
    expected_offset_next = expected_offset;
    res.accepted         = 1'b0;

    unique case (msg.opcode)
      cbt_pkg::OP_ANNOUNCE: begin
        session_active_next  = 1'b1;
        held_stream_next     = msg.stream_key;
        held_version_next    = msg.meta_rev;
        held_kind_next       = msg.blob_kind;
        held_total_next      = msg.total_length;
        held_check_next      = msg.check_value;
        expected_offset_next = 32'd0;
        res.accepted         = 1'b1;
      end
      cbt_pkg::OP_CHUNK: begin
        priority if (!session_active) begin
          code = cbt_pkg::ERR_NO_SESSION;
        end else if (!id_match) begin
          code = cbt_pkg::ERR_IDENTITY;
        end else if (msg.chunk_length == 16'd0) begin
          code = cbt_pkg::ERR_EMPTY;
        end else if (msg.chunk_offset != expected_offset) begin
          code = cbt_pkg::ERR_GAP;
        end else if (msg.chunk_offset > held_total) begin
          code = cbt_pkg::ERR_BEYOND;
        end else if (len_ext > room) begin
          code = cbt_pkg::ERR_OVERRUN;
        end else begin
          expected_offset_next = msg.chunk_offset + len_ext;
        end
        res.accepted = (code == cbt_pkg::ERR_OK);
        close = (code != cbt_pkg::ERR_OK) && (code != cbt_pkg::ERR_NO_SESSION);
      end
      cbt_pkg::OP_COMPLETE: begin
        priority if (!session_active) begin
          code = cbt_pkg::ERR_NO_SESSION;
        end else if (!id_match) begin
          code = cbt_pkg::ERR_IDENTITY;
        end else if (msg.check_value != held_check) begin
          code = cbt_pkg::ERR_CHECKSUM;
        end else if (expected_offset != held_total) begin
          code = cbt_pkg::ERR_INCOMPLETE;
        end else begin
          code = cbt_pkg::ERR_OK;
        end
        res.accepted = (code == cbt_pkg::ERR_OK);
        close = 1'b1;
      end
      default: begin
        // unused opcode: leave state alone, report no error
        code = cbt_pkg::ERR_OK;
      end
    endcase

    if (close) begin
      session_active_next  = 1'b0;
      held_stream_next     = 32'd0;
      held_version_next    = 32'd0;
      held_kind_next       = 32'd0;
      held_total_next      = 32'd0;
      held_check_next      = 64'd0;
      expected_offset_next = 32'd0;
    end

    res.error_code   = code;
    res.session_open = session_active_next;
  end

  // advance the session only when the beat moves on to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      session_active  <= 1'b0;
      held_stream     <= 32'd0;
      held_version    <= 32'd0;
      held_kind       <= 32'd0;
      held_total      <= 32'd0;
      held_check      <= 64'd0;
      expected_offset <= 32'd0;
    end else if (take) begin
      session_active  <= session_active_next;
      held_stream     <= held_stream_next;
      held_version    <= held_version_next;
      held_kind       <= held_kind_next;
      held_total      <= held_total_next;
      held_check      <= held_check_next;
      expected_offset <= expected_offset_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cbt_out_stage.sv
// Result register stage of the checker: holds one result beat.
// Depends on cbt_pkg for the result type.
`default_nettype none

module cbt_out_stage (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cbt_pkg::result_t             res,
  input  wire logic                         res_valid,
  output      logic                         res_ready,
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  output      logic [cbt_pkg::OutDataW-1:0] m_tdata
);

  cbt_pkg::result_t held;

  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = {{(cbt_pkg::OutDataW - $bits(cbt_pkg::result_t)){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/chunked_blob_transfer_checker.sv
// Top level of the chunked blob transfer checker.
// Depends on cbt_pkg, cbt_in_stage, cbt_engine and cbt_out_stage.
`default_nettype none

// Checks a stream of decoded announce / chunk / complete messages against one
// open blob session and answers each message with exactly one result beat.
// Throughput is one message per clock while the receiver keeps m_tready high;
// a message is registered in the input register, then passes through the check
// logic into the result register. The session registers update as a message
// passes into the result register, so the next message is checked against the
// updated session. Ready on the input runs combinationally back from m_tready
// through both register stages.
module chunked_blob_transfer_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  // stream_key[31:0], meta_rev[63:32], blob_kind[95:64],
  // total_length[127:96], check_value[191:128], chunk_offset[223:192],
  // chunk_length[239:224]
  input  wire logic [cbt_pkg::InDataW-1:0]  s_tdata,
  // opcode[1:0]
  input  wire logic [cbt_pkg::OpW-1:0]      s_tuser,
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  // accepted[0], error_code[4:1], session_open[5], zero[7:6]
  output      logic [cbt_pkg::OutDataW-1:0] m_tdata
);

  cbt_pkg::msg_t    msg;
  cbt_pkg::result_t res;
  logic             msg_valid;
  logic             res_ready;

  cbt_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .msg       (msg),
    .msg_valid (msg_valid),
    .msg_ready (res_ready)
  );

  cbt_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg),
    .take (msg_valid && res_ready),
    .res  (res)
  );

  cbt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (msg_valid),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

FILE: sv/cbt_checker.sv
// Port-level assertions for the chunked blob transfer checker, bound to the top.
// Depends on cbt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cbt_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [cbt_pkg::OutDataW-1:0] m_tdata
);

  logic [cbt_pkg::CodeW-1:0] code;

  assign code = m_tdata[4:1];

  `ASSERT_HOLD(a_out_hold, clk, rst, m_tvalid, m_tready)
  `ASSERT_IMPL(a_ok_no_code, clk, rst, (m_tvalid && m_tdata[0]) |-> (code == cbt_pkg::ERR_OK))
  `ASSERT_IMPL(a_code_range, clk, rst, m_tvalid |-> (code <= cbt_pkg::ERR_INCOMPLETE))
  `ASSERT_IMPL(a_fail_closed, clk, rst, (m_tvalid && (code != cbt_pkg::ERR_OK)) |-> !m_tdata[5])

endmodule

bind chunked_blob_transfer_checker cbt_checker u_cbt_checker (.*);

`default_nettype wire

FILE: verif/chunked_blob_transfer_checker_tb.sv
// Testbench for chunked_blob_transfer_checker: directed and random message streams.
// Depends on cbt_pkg and the checker RTL; predicts each result beat and compares it.
`timescale 1ns / 100ps

module chunked_blob_transfer_checker_tb;

  localparam logic [cbt_pkg::OpW-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_AT = 120;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [cbt_pkg::InDataW-1:0] s_tdata = '0;
  logic [cbt_pkg::OpW-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [cbt_pkg::OutDataW-1:0] m_tdata;

  chunked_blob_transfer_checker dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Predicted session state
  logic        sess_open;
  logic [31:0] held_stream, held_version, held_kind, held_total, next_offset;
  logic [63:0] held_check;

  cbt_pkg::msg_t    messages_pending[$];
  cbt_pkg::result_t verdicts_due[$];
  cbt_pkg::msg_t    on_bus;
  cbt_pkg::result_t got;
  cbt_pkg::result_t want;
  int      total_items = 1;
  int      sent_count = 0;
  int      recv_count = 0;
  int      err_count = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      cycle_count = 0;

  function automatic void close_session();
    sess_open = 1'b0;
    held_stream = '0;
    held_version = '0;
    held_kind = '0;
    held_total = '0;
    held_check = '0;
    next_offset = '0;
  endfunction

  function automatic cbt_pkg::result_t judge_message(cbt_pkg::msg_t m);
    cbt_pkg::result_t r;
    logic [cbt_pkg::CodeW-1:0] code;
    logic same_id;
    code = cbt_pkg::ERR_OK;
    r = '0;
    same_id = (m.stream_key == held_stream) && (m.meta_rev == held_version);
    case (m.opcode)
      cbt_pkg::OP_ANNOUNCE: begin
        sess_open = 1'b1;
        held_stream = m.stream_key;
        held_version = m.meta_rev;
        held_kind = m.blob_kind;
        held_total = m.total_length;
        held_check = m.check_value;
        next_offset = '0;
        r.accepted = 1'b1;
      end
      cbt_pkg::OP_CHUNK: begin
        if (!sess_open) code = cbt_pkg::ERR_NO_SESSION;
        else if (!same_id) code = cbt_pkg::ERR_IDENTITY;
        else if (m.chunk_length == 16'd0) code = cbt_pkg::ERR_EMPTY;
        else if (m.chunk_offset != next_offset) code = cbt_pkg::ERR_GAP;
        else if (m.chunk_offset > held_total) code = cbt_pkg::ERR_BEYOND;
        else if ({16'd0, m.chunk_length} > held_total - m.chunk_offset)
          code = cbt_pkg::ERR_OVERRUN;
        else next_offset = m.chunk_offset + {16'd0, m.chunk_length};
        r.accepted = (code == cbt_pkg::ERR_OK);
        if (code != cbt_pkg::ERR_OK && code != cbt_pkg::ERR_NO_SESSION) close_session();
      end
      cbt_pkg::OP_COMPLETE: begin
        if (!sess_open) code = cbt_pkg::ERR_NO_SESSION;
        else if (!same_id) code = cbt_pkg::ERR_IDENTITY;
        else if (m.check_value != held_check) code = cbt_pkg::ERR_CHECKSUM;
        else if (next_offset != held_total) code = cbt_pkg::ERR_INCOMPLETE;
        r.accepted = (code == cbt_pkg::ERR_OK);
        close_session();
      end
      default: ;
    endcase
    r.error_code = code;
    r.session_open = sess_open;
    return r;
  endfunction

  function automatic cbt_pkg::msg_t make_msg(logic [cbt_pkg::OpW-1:0] op, logic [31:0] sid,
                                             logic [31:0] ver, logic [31:0] kind,
                                             logic [31:0] total, logic [63:0] chk,
                                             logic [31:0] off, logic [15:0] len);
    cbt_pkg::msg_t m;
    m.opcode = op;
    m.stream_key = sid;
    m.meta_rev = ver;
    m.blob_kind = kind;
    m.total_length = total;
    m.check_value = chk;
    m.chunk_offset = off;
    m.chunk_length = len;
    return m;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cbt_pkg::msg_t noise_msg();
    return make_msg(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom, rand64(),
                    $urandom, 16'($urandom));
  endfunction

  // 0: free run, 1: sender idles, 2: receiver stalls, 3: both
  function automatic int phase_of(int n);
    int p;
    p = n * 4 / total_items;
    return (p > 3) ? 3 : p;
  endfunction

  // Queue one well-formed session with random content, sometimes broken on purpose.
  task automatic queue_session(inout int counted);
    logic [31:0] sid, ver, total, off;
    logic [63:0] chk;
    logic [15:0] lens[$];
    logic [15:0] len;
    cbt_pkg::msg_t m;
    int n;
    sid = $urandom;
    ver = $urandom;
    chk = rand64();
    n = $urandom_range(1, 6);
    total = '0;
    for (int i = 0; i < n; i++) begin
      len = ($urandom_range(15) == 0) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 64));
      lens.push_back(len);
      total += {16'd0, len};
    end
    if ($urandom_range(9) == 0) total += $urandom_range(1, 50);
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, sid, ver, $urandom, total, chk,
                                        $urandom, 16'($urandom)));
    counted++;
    off = '0;
    foreach (lens[i]) begin
      m = make_msg(cbt_pkg::OP_CHUNK, sid, ver, $urandom, $urandom, rand64(), off, lens[i]);
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(3))
          0: m.stream_key[$urandom_range(31)] ^= 1'b1;
          1: m.meta_rev[$urandom_range(31)] ^= 1'b1;
          2: m.chunk_length = '0;
          default: m.chunk_offset = off + $urandom_range(1, 3);
        endcase
      end else if ($urandom_range(99) < 3) begin
        m.chunk_length = 16'hFFFF;
      end
      messages_pending.push_back(m);
      counted++;
      off += {16'd0, lens[i]};
    end
    if ($urandom_range(19) != 0) begin
      m = make_msg(cbt_pkg::OP_COMPLETE, sid, ver, $urandom, $urandom, chk, $urandom,
                   16'($urandom));
      if ($urandom_range(99) < 10) m.check_value[$urandom_range(63)] ^= 1'b1;
      else if ($urandom_range(99) < 5) m.stream_key ^= 32'h1;
      messages_pending.push_back(m);
      counted++;
    end
  endtask

  task automatic queue_directed();
    logic [31:0] ones32;
    logic [63:0] ones64;
    ones32 = '1;
    ones64 = '1;
    // No session yet: chunk and complete are refused, unused opcode ignored
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'h5, 32'h6, 0, 0, 0, 0, 16'd4));
    messages_pending.push_back(make_msg(cbt_pkg::OP_COMPLETE, 32'h5, 32'h6, 0, 0, 64'h7,
                                        0, 0));
    messages_pending.push_back(make_msg(OP_UNUSED, ones32, ones32, ones32, ones32, ones64,
                                        ones32, 16'hFFFF));
    // Zero-length blob completes right away
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 0, 0, 0, 0, 0, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_COMPLETE, 0, 0, 0, 0, 0, 0, 0));
    // All-ones identity and length, largest chunk, then an empty chunk
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, ones32, ones32, ones32, ones32,
                                        ones64, ones32, 16'hFFFF));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, ones32, ones32, 0, 0, 0, 0,
                                        16'hFFFF));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, ones32, ones32, 0, 0, 0, 32'hFFFF,
                                        16'd0));
    // Unused opcode during a session, then a gap
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hA, 32'hB, 32'hC, 32'd100,
                                        64'hD, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'hA, 32'hB, 0, 0, 0, 0, 16'd40));
    messages_pending.push_back(make_msg(OP_UNUSED, 32'hA, 32'hB, 0, 0, 0, 32'd40, 16'd10));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'hA, 32'hB, 0, 0, 0, 32'd50,
                                        16'd10));
    // Identity mismatches on stream and on version
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hA, 32'hB, 0, 32'd100,
                                        64'hD, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'hA1, 32'hB, 0, 0, 0, 0, 16'd10));
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hA, 32'hB, 0, 32'd100,
                                        64'hD, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'hA, 32'hB1, 0, 0, 0, 0, 16'd10));
    // Overrun
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hA, 32'hB, 0, 32'd100,
                                        64'hD, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'hA, 32'hB, 0, 0, 0, 0, 16'd101));
    // Announce replaces an open session, then a bad checksum
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hA, 32'hB, 0, 32'd100,
                                        64'hD, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hE, 32'hF, 0, 32'd20,
                                        64'h11, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'hE, 32'hF, 0, 0, 0, 0, 16'd20));
    messages_pending.push_back(make_msg(cbt_pkg::OP_COMPLETE, 32'hE, 32'hF, 0, 0, 64'h12,
                                        0, 0));
    // Incomplete blob, then complete with a wrong identity
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hE, 32'hF, 0, 32'd20,
                                        64'h11, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_CHUNK, 32'hE, 32'hF, 0, 0, 0, 0, 16'd10));
    messages_pending.push_back(make_msg(cbt_pkg::OP_COMPLETE, 32'hE, 32'hF, 0, 0, 64'h11,
                                        0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_ANNOUNCE, 32'hE, 32'hF, 0, 32'd0,
                                        64'h11, 0, 0));
    messages_pending.push_back(make_msg(cbt_pkg::OP_COMPLETE, 32'hE0, 32'hF, 0, 0, 64'h11,
                                        0, 0));
  endtask

  initial begin
    int counted;
    counted = 0;
    close_session();
    queue_directed();
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 15) begin
        messages_pending.push_back(noise_msg());
        if (messages_pending[$].opcode != OP_UNUSED) counted++;
      end else begin
        queue_session(counted);
      end
    end
    total_items = messages_pending.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_items) @(posedge clk);
    for (int i = 0; i < 1000 && verdicts_due.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $error("%0d expected results never arrived", verdicts_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Sender: hold the beat while stalled, otherwise maybe offer the next message
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        verdicts_due.push_back(judge_message(on_bus));
        sent_count <= sent_count + 1;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (messages_pending.size() != 0 &&
            $urandom_range(99) >= ((phase_of(sent_count) == 1) ? 84 :
                                   (phase_of(sent_count) == 3) ? 12 : 0)) begin
          on_bus = messages_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= on_bus[cbt_pkg::InDataW-1:0];
          s_tuser <= on_bus.opcode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off early on, so the pipeline fills and backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && recv_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(cbt_pkg::result_t)-1:0];
        recv_count <= recv_count + 1;
        if (verdicts_due.size() == 0) begin
          $error("result beat with no message outstanding: %h", m_tdata);
          err_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            err_count++;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            err_count++;
          end
          if (got.session_open !== want.session_open) begin
            $error("session_open: expected %0d, got %0d", want.session_open,
                   got.session_open);
            err_count++;
          end
        end
      end
      m_tready <= (hold_left == 0) &&
                  ($urandom_range(99) >= ((phase_of(recv_count) == 2) ? 84 :
                                          (phase_of(recv_count) == 3) ? 12 : 0));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
